@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and quiet in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(label, cond, nxt, msg) \
  `ASSERT_CLK(label, (cond) |=> (nxt), msg)

`endif

@@ rtl/ric_pkg.sv @@
package ric_pkg;

  localparam int QUAD_W  = 11;
  localparam int LIN_W   = 13;
  localparam int CONST_W = 12;
  localparam int STEPS_W = 6;
  localparam int OUTC_W  = 2;
  localparam int SC_W    = 10;
  localparam int SO_W    = 2;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;
  localparam int COEF_W  = 24;
  localparam int DIV_W   = 13;
  localparam int DD_W    = 8;

  localparam logic [CIDX_W-1:0] CFG_SHIFT_CONST  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SHIFT_OFFSET = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MIN_STEPS    = 2'd2;

  localparam logic [OUTC_W-1:0] OUTC_SURVIVED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_NOT_DIV  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_FEW      = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_ZERO     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NEGA,
    ST_DIV,
    ST_NEGQ,
    ST_UPD
  } state_t;

endpackage

@@ rtl/recurrence_integrality_check.sv @@
// channel  ports                                          direction
// input    start, busy, in_quad/lin/const_coef            start when busy low
// result   out_valid, out_survivor/steps_reached/outcome  one-cycle strobe
// config   cfg_we, cfg_index, cfg_wdata                   write, no wait
// Terms are held NW = MAGNITUDE_BITS+24 bits wide and processed one bit a cycle.
// Each recurrence step runs a serial multiply, a serial exact division, a serial
// negation of a negative numerator before and of its quotient after the division,
// and an update state; an item runs up to STEP_LIMIT-1 steps through the single
// bit-serial multiply/divide loop, and no new item is taken until it is done.
// rst_n is synchronous; the result is strobed once and cannot be stalled.
module recurrence_integrality_check #(
  parameter int STEP_LIMIT     = 40,
  parameter int MAGNITUDE_BITS = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ric_pkg::QUAD_W-1:0]   in_quad_coef,
  input  logic signed [ric_pkg::LIN_W-1:0]    in_lin_coef,
  input  logic        [ric_pkg::CONST_W-1:0]  in_const_coef,
  output logic                                out_valid,
  output logic                                out_survivor,
  output logic        [ric_pkg::STEPS_W-1:0]  out_steps_reached,
  output logic        [ric_pkg::OUTC_W-1:0]   out_outcome,
  input  logic                                cfg_we,
  input  logic        [ric_pkg::CIDX_W-1:0]   cfg_index,
  input  logic        [ric_pkg::CFG_W-1:0]    cfg_wdata
);
  import ric_pkg::*;

  localparam int NW = MAGNITUDE_BITS + 24;
  localparam int CW = $clog2(NW);
  localparam int AW = COEF_W + 2;

  state_t state_r, state_nxt;

  logic signed [SC_W-1:0]   sc_r;
  logic        [SO_W-1:0]   so_r;
  logic        [STEPS_W-1:0] ms_r;

  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, num_r, num_nxt;
  logic signed [COEF_W-1:0] pn_r, pn_nxt, dp_r, dp_nxt, cs_r, cs_nxt, dc_r, dc_nxt;
  logic signed [COEF_W-1:0] aq2_r, aq2_nxt;
  logic [DIV_W-1:0] d_r, d_nxt, rem_r, rem_nxt;
  logic [DD_W-1:0]  dd_r, dd_nxt;
  logic [STEPS_W-1:0] n_r, n_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic neg_r, neg_nxt, seen_r, seen_nxt;
  logic hi_r, hi_nxt, bm_r, bm_nxt, lo_r, lo_nxt, qnz_r, qnz_nxt;
  logic curz_r, curz_nxt;

  logic out_valid_r, out_valid_nxt, surv_r, surv_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic [OUTC_W-1:0]  outc_r, outc_nxt;

  logic signed [AW-1:0] sum, mc, mp;
  logic [DIV_W:0] tdiv;
  logic qbit, nbit, last, exc, zero_any;
  logic [OUTC_W-1:0] fin_outc;
  logic [STEPS_W-1:0] fin_steps;
  logic signed [COEF_W-1:0] aq_x, bq_x, cq_x, c_x;

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_survivor      = surv_r;
  assign out_steps_reached = steps_r;
  assign out_outcome       = outc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= 10'sd64;
      so_r <= '0;
      ms_r <= 6'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIFT_CONST:  sc_r <= $signed(cfg_wdata[SC_W-1:0]);
        CFG_SHIFT_OFFSET: so_r <= cfg_wdata[SO_W-1:0];
        CFG_MIN_STEPS:    ms_r <= cfg_wdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;   prev_r <= prev_nxt;  num_r <= num_nxt;
    pn_r <= pn_nxt;     dp_r <= dp_nxt;      cs_r <= cs_nxt;   dc_r <= dc_nxt;
    aq2_r <= aq2_nxt;   d_r <= d_nxt;        rem_r <= rem_nxt; dd_r <= dd_nxt;
    n_r <= n_nxt;       cnt_r <= cnt_nxt;    acc_r <= acc_nxt;
    neg_r <= neg_nxt;   seen_r <= seen_nxt;
    hi_r <= hi_nxt;     bm_r <= bm_nxt;      lo_r <= lo_nxt;   qnz_r <= qnz_nxt;
    curz_r <= curz_nxt;
    surv_r <= surv_nxt; steps_r <= steps_nxt; outc_r <= outc_nxt;
  end

  assign aq_x = COEF_W'(in_quad_coef);
  assign bq_x = COEF_W'(in_lin_coef);
  assign cq_x = COEF_W'($signed({1'b0, in_const_coef}));
  assign c_x  = COEF_W'(sc_r);

  assign last = (cnt_r == '0);
  assign mc   = cur_r[0]  ? (last ? -AW'(pn_r) : AW'(pn_r)) : '0;
  assign mp   = prev_r[0] ? (last ? -AW'(cs_r) : AW'(cs_r)) : '0;
  assign sum  = acc_r + mc - mp;

  assign nbit = seen_r ? ~num_r[0] : num_r[0];
  assign tdiv = {rem_r, num_r[NW-1]};
  assign qbit = (tdiv >= {1'b0, d_r});

  assign exc      = hi_r | (bm_r & lo_r);
  assign zero_any = ~qnz_r | curz_r;
  assign fin_steps = exc ? n_r : STEPS_W'(STEP_LIMIT);

  always_comb begin
    if (fin_steps < ms_r)
      fin_outc = OUTC_FEW;
    else if (zero_any)
      fin_outc = OUTC_ZERO;
    else
      fin_outc = OUTC_SURVIVED;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;   prev_nxt = prev_r;  num_nxt = num_r;
    pn_nxt = pn_r;     dp_nxt = dp_r;      cs_nxt = cs_r;    dc_nxt = dc_r;
    aq2_nxt = aq2_r;   d_nxt = d_r;        rem_nxt = rem_r;  dd_nxt = dd_r;
    n_nxt = n_r;       cnt_nxt = cnt_r;    acc_nxt = acc_r;
    neg_nxt = neg_r;   seen_nxt = seen_r;
    hi_nxt = hi_r;     bm_nxt = bm_r;      lo_nxt = lo_r;    qnz_nxt = qnz_r;
    curz_nxt = curz_r;
    out_valid_nxt = 1'b0;
    surv_nxt = surv_r; steps_nxt = steps_r; outc_nxt = outc_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          prev_nxt  = NW'(1);
          cur_nxt   = NW'(in_const_coef);
          curz_nxt  = (in_const_coef == '0);
          n_nxt     = STEPS_W'(1);
          aq2_nxt   = aq_x <<< 1;
          pn_nxt    = aq_x + bq_x + cq_x;
          dp_nxt    = (aq_x <<< 1) + aq_x + bq_x;
          case (so_r)
            2'd0: begin cs_nxt = c_x;      dc_nxt = (c_x <<< 1) + c_x;    end
            2'd1: begin cs_nxt = '0;       dc_nxt = c_x;                  end
            2'd2: begin cs_nxt = c_x;      dc_nxt = -c_x;                 end
            default: begin cs_nxt = c_x <<< 2; dc_nxt = -((c_x <<< 1) + c_x); end
          endcase
          d_nxt     = DIV_W'(4);
          dd_nxt    = DD_W'(5);
          cnt_nxt   = CW'(NW - 1);
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        cur_nxt  = {cur_r[0], cur_r[NW-1:1]};
        prev_nxt = {prev_r[0], prev_r[NW-1:1]};
        num_nxt  = {sum[0], num_r[NW-1:1]};
        acc_nxt  = sum >>> 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (last) begin
          neg_nxt  = sum[0];
          seen_nxt = 1'b0;
          cnt_nxt  = CW'(NW - 1);
          rem_nxt  = '0;
          hi_nxt = 1'b0; bm_nxt = 1'b0; lo_nxt = 1'b0; qnz_nxt = 1'b0;
          state_nxt = sum[0] ? ST_NEGA : ST_DIV;
        end
      end

      ST_NEGA, ST_NEGQ: begin
        num_nxt  = {nbit, num_r[NW-1:1]};
        seen_nxt = seen_r | num_r[0];
        cnt_nxt  = cnt_r - 1'b1;
        if (last) begin
          cnt_nxt   = CW'(NW - 1);
          seen_nxt  = 1'b0;
          state_nxt = (state_r == ST_NEGA) ? ST_DIV : ST_UPD;
        end
      end

      ST_DIV: begin
        rem_nxt = qbit ? DIV_W'(tdiv - {1'b0, d_r}) : tdiv[DIV_W-1:0];
        num_nxt = {num_r[NW-2:0], qbit};
        cnt_nxt = cnt_r - 1'b1;
        if (qbit) begin
          qnz_nxt = 1'b1;
          if (cnt_r > CW'(MAGNITUDE_BITS))  hi_nxt = 1'b1;
          if (cnt_r == CW'(MAGNITUDE_BITS)) bm_nxt = 1'b1;
          if (cnt_r < CW'(MAGNITUDE_BITS))  lo_nxt = 1'b1;
        end
        if (last) begin
          cnt_nxt = CW'(NW - 1);
          if (rem_nxt != '0) begin
            out_valid_nxt = 1'b1;
            surv_nxt  = 1'b0;
            steps_nxt = n_r;
            outc_nxt  = OUTC_NOT_DIV;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = neg_r ? ST_NEGQ : ST_UPD;
          end
        end
      end

      ST_UPD: begin
        prev_nxt  = cur_r;
        cur_nxt   = num_r;
        curz_nxt  = ~qnz_r;
        if (exc || (n_r + 1'b1) == STEPS_W'(STEP_LIMIT)) begin
          out_valid_nxt = 1'b1;
          surv_nxt  = (fin_outc == OUTC_SURVIVED);
          steps_nxt = fin_steps;
          outc_nxt  = fin_outc;
          state_nxt = ST_IDLE;
        end else begin
          n_nxt   = n_r + 1'b1;
          pn_nxt  = pn_r + dp_r;
          dp_nxt  = dp_r + aq2_r;
          cs_nxt  = cs_r + dc_r;
          dc_nxt  = dc_r + (c_x <<< 1);
          d_nxt   = d_r + DIV_W'(dd_r);
          dd_nxt  = dd_r + DD_W'(2);
          acc_nxt = '0;
          cnt_nxt = CW'(NW - 1);
          state_nxt = ST_MUL;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted start did not raise busy")
  `ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `ASSERT_CLK(a_rem_below_d, state_r == ST_DIV |-> rem_r < d_r, "remainder not below divisor")
  `ASSERT_CLK(a_surv_code, out_valid |-> (out_survivor == (out_outcome == OUTC_SURVIVED)),
              "survivor flag disagrees with outcome")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ric_pkg::*;

  localparam int  STEP_LIMIT = 40;
  localparam int  MAG_BITS   = 100;
  localparam int  ROW_TARGET = 1450;
  localparam longint CYCLE_LIMIT = 100_000_000;
  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic               survivor;
    logic [STEPS_W-1:0] steps;
    logic [OUTC_W-1:0]  outcome;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [QUAD_W-1:0] in_quad_coef = '0;
  logic signed [LIN_W-1:0]  in_lin_coef = '0;
  logic [CONST_W-1:0]       in_const_coef = '0;
  logic                     out_valid;
  logic                     out_survivor;
  logic [STEPS_W-1:0]       out_steps_reached;
  logic [OUTC_W-1:0]        out_outcome;
  logic                     cfg_we = 1'b0;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  logic signed [SC_W-1:0] shift_c = 10'sd64;
  logic [SO_W-1:0]        shift_r = '0;
  logic [STEPS_W-1:0]     min_st = 6'd12;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       rows_sent = 0;
  longint   cycles = 0;

  // known integral families: aq, bq, cq, c (with r = 0)
  int fam_aq[4] = '{16, 11, 7, 10};
  int fam_bq[4] = '{16, 11, 7, 10};
  int fam_cq[4] = '{4, 3, 2, 3};
  int fam_c[4]  = '{0, -1, -8, 9};

  recurrence_integrality_check i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quad_coef(in_quad_coef), .in_lin_coef(in_lin_coef), .in_const_coef(in_const_coef),
    .out_valid(out_valid), .out_survivor(out_survivor),
    .out_steps_reached(out_steps_reached), .out_outcome(out_outcome),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic verdict_t run_recurrence(logic signed [QUAD_W-1:0] aq,
                                              logic signed [LIN_W-1:0] bq,
                                              logic [CONST_W-1:0] cq);
    logic signed [191:0] prev, cur, num, dd, mag, bound;
    longint   pn, dr, csh;
    int       k;
    bit       div_ok;
    verdict_t v;
    prev = 1;
    cur = $signed({180'b0, cq});
    bound = 1;
    bound = bound << MAG_BITS;
    div_ok = 1'b1;
    for (k = 1; k < STEP_LIMIT; k++) begin
      pn = longint'(aq) * k * k + longint'(bq) * k + longint'(cq);
      dr = k - longint'(shift_r);
      csh = longint'(shift_c) * dr * dr;
      dd = (k + 1) * (k + 1);
      num = cur * pn - prev * csh;
      if (num % dd != 0) begin
        div_ok = 1'b0;
        break;
      end
      prev = cur;
      cur = num / dd;
      mag = (cur < 0) ? -cur : cur;
      if (mag > bound) break;
    end
    v.steps = k[STEPS_W-1:0];
    if (!div_ok) v.outcome = OUTC_NOT_DIV;
    else if (k < min_st) v.outcome = OUTC_FEW;
    else if (cur == 0 || prev == 0) v.outcome = OUTC_ZERO;
    else v.outcome = OUTC_SURVIVED;
    v.survivor = (v.outcome == OUTC_SURVIVED);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected word: surv %0d steps %0d outcome %0d", $time,
                 out_survivor, out_steps_reached, out_outcome);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_survivor !== exp_v.survivor) begin
          $display("%0t: survivor exp %0d got %0d", $time, exp_v.survivor, out_survivor);
          errors++;
        end
        if (out_steps_reached !== exp_v.steps) begin
          $display("%0t: steps exp %0d got %0d", $time, exp_v.steps, out_steps_reached);
          errors++;
        end
        if (out_outcome !== exp_v.outcome) begin
          $display("%0t: outcome exp %0d got %0d", $time, exp_v.outcome, out_outcome);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; leaves start high
  task automatic send_row(input int aq, input int bq, input int cq);
    start <= 1'b1;
    in_quad_coef <= QUAD_W'(aq);
    in_lin_coef <= LIN_W'(bq);
    in_const_coef <= CONST_W'(cq);
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(run_recurrence(QUAD_W'(aq), LIN_W'(bq), CONST_W'(cq)));
    rows_sent++;
  endtask

  task automatic sender_gap();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: n = 0;
      9:          n = $urandom_range(60, 20);
      default:    n = $urandom_range(3, 1);
    endcase
    repeat (n) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHIFT_CONST:  shift_c = data;
      CFG_SHIFT_OFFSET: shift_r = data[SO_W-1:0];
      CFG_MIN_STEPS:    min_st = data[STEPS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int c, input int r, input int m);
    drain();
    write_reg(CFG_SHIFT_CONST, CFG_W'(c));
    write_reg(CFG_SHIFT_OFFSET, CFG_W'(r));
    write_reg(CFG_MIN_STEPS, CFG_W'(m));
  endtask

  task automatic test_reset_config();
    send_row(11, 11, 3);
    send_row(0, 0, 0);
    sender_gap();
    send_row(16, 16, 4);
  endtask

  task automatic test_families();
    for (int f = 0; f < 4; f++) begin
      set_config(fam_c[f], 0, 3);
      send_row(fam_aq[f], fam_bq[f], fam_cq[f]);
    end
    set_config(-1, 0, 40);    // survivor stopped early by magnitude: too few
    send_row(11, 11, 3);
    set_config(0, 0, 63);
    send_row(0, 0, 0);
  endtask

  task automatic test_field_extremes();
    set_config(-256, 3, 0);
    send_row(-1024, -4096, 0);
    send_row(1023, 4095, 4095);
    send_row(0, 0, 0);         // all-zero coefficients
    send_row(-1024, 4095, 4095);
    set_config(256, 2, 3);
    send_row(1023, -4096, 4095);
    send_row(0, 0, 1);
    send_row(0, 0, 4);
    drain();
    write_reg(CFG_UNMAPPED, 10'h3ff);
    write_reg(CFG_UNMAPPED, 10'h000);
    send_row(16, 16, 4);
  endtask

  task automatic test_drain_pause();
    set_config(-8, 0, 12);
    send_row(7, 7, 2);
    drain();
    send_row(7, 7, 2);
    send_row($urandom, $urandom, $urandom);
  endtask

  task automatic test_random_rows();
    int f, m;
    while (rows_sent < ROW_TARGET) begin
      f = $urandom_range(3);
      m = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(40, 3);
      if ($urandom_range(1))
        set_config(fam_c[f], 0, m);
      else
        set_config($urandom_range(512) - 256, $urandom_range(3), m);
      if ($urandom_range(7) == 0) write_reg(CFG_UNMAPPED, CFG_W'($urandom));
      repeat (60) begin
        if ($urandom_range(3) == 0 && shift_r == 0 && shift_c == fam_c[f])
          send_row(fam_aq[f], fam_bq[f], fam_cq[f]);
        else if ($urandom_range(3) == 0)
          send_row($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8));
        else
          send_row($urandom, $urandom, $urandom);
        sender_gap();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_families();
    test_field_extremes();
    test_drain_pause();
    test_random_rows();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ recurrence_integrality_check.f @@
+incdir+rtl
rtl/ric_pkg.sv
rtl/recurrence_integrality_check.sv
verif/testbench.sv
